// ===== rtl/fppa_pkg.sv =====
`timescale 1ns / 1ps

package fppa_pkg;

  // Field widths of the request, the result and the configuration port.
  localparam int SIZE_W    = 16;
  localparam int COUNT_W   = 3;
  localparam int PART_W    = 3;
  localparam int POLICY_W  = 2;
  localparam int CFG_IDX_W = 3;

  // Number of capacity registers in the configuration space.
  localparam int REG_SLOTS = 6;

  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [PART_W-1:0]    part_t;
  typedef logic [POLICY_W-1:0]  policy_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Placement policy codes. The one unused code behaves as first fit.
  localparam policy_t FIT_FIRST = 2'd0;
  localparam policy_t FIT_BEST  = 2'd1;
  localparam policy_t FIT_WORST = 2'd2;

  // Configuration register indexes. Capacities follow from the first one up.
  localparam cfg_idx_t CFG_FIT_POLICY      = 3'd0;
  localparam cfg_idx_t CFG_PARTITION_COUNT = 3'd1;
  localparam cfg_idx_t CFG_PARTITION0_SIZE = 3'd2;

  // Reset values of the configuration registers.
  localparam policy_t FIT_POLICY_RESET      = FIT_FIRST;
  localparam count_t  PARTITION_COUNT_RESET = 3'd5;
  localparam size_t   SIZE_RESET [REG_SLOTS] = '{16'd50, 16'd100, 16'd90, 16'd200,
                                                  16'd60, 16'd0};

endpackage

// ===== rtl/fppa_req_if.sv =====
`timescale 1ns / 1ps

interface fppa_req_if;
  logic               valid;
  logic               ready;
  fppa_pkg::size_t    request_size;

  modport source (output valid, output request_size, input ready);
  modport sink   (input valid, input request_size, output ready);
endinterface

// ===== rtl/fppa_res_if.sv =====
`timescale 1ns / 1ps

interface fppa_res_if;
  logic               valid;
  logic               ready;
  logic               granted;
  fppa_pkg::part_t    chosen_partition;
  fppa_pkg::size_t    free_after;

  modport source (output valid, output granted, output chosen_partition,
                  output free_after, input ready);
  modport sink   (input valid, input granted, input chosen_partition,
                  input free_after, output ready);
endinterface

// ===== rtl/fppa_cfg_if.sv =====
`timescale 1ns / 1ps

interface fppa_cfg_if;
  logic               valid;
  logic               ready;
  fppa_pkg::cfg_idx_t index;
  fppa_pkg::size_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fit_policy_partition_allocator_unit.sv =====
`timescale 1ns / 1ps
// A request is taken only in the idle state; the scan then reads one allocated amount
// per cycle from the memory for each active partition (partition_count saturated to
// NUM_PARTITIONS), and the finish state loads the result register, and for a grant writes
// back the allocated amount, once that register is free. A zero request or a count of zero
// skips the scan. No new request is taken until the result of the last one is loaded.
// Reset (rst, synchronous) restores every configuration register to its reset value,
// marks every partition empty through per-entry valid bits and drops any pending result.
module fit_policy_partition_allocator_unit #(
  parameter int NUM_PARTITIONS = 6
) (
  input  logic       clk,
  input  logic       rst,
  fppa_req_if.sink   req,
  fppa_res_if.source res,
  fppa_cfg_if.sink   cfg
);

  localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Config regs: the user changes them only while no request is in flight; not enforced.
  fppa_pkg::policy_t fit_policy;
  fppa_pkg::count_t  partition_count;
  fppa_pkg::size_t   part_size [fppa_pkg::REG_SLOTS];

  // Allocated amount of each partition lives in a synchronous memory. The valid
  // bits stand in for the all-zero reset: an entry never written reads as zero.
  fppa_pkg::size_t   alloc_mem [NUM_PARTITIONS];
  logic [NUM_PARTITIONS-1:0] alloc_valid;
  fppa_pkg::size_t   rd_amt;
  logic              rd_valid;
  idx_t              rd_addr;
  logic              wr_en;

  // Request in flight and the best candidate seen so far in the scan.
  state_t            state;
  fppa_pkg::size_t   req_size;
  idx_t              scan_idx;
  logic              found;
  idx_t              pick_idx;
  fppa_pkg::size_t   pick_free;
  fppa_pkg::size_t   pick_amt;

  // Result register; it decouples the scan from a stalled consumer.
  logic              res_valid;
  logic              res_granted;
  fppa_pkg::part_t   res_partition;
  fppa_pkg::size_t   res_free;

  fppa_pkg::count_t  count_sat;
  logic              count_zero;
  idx_t              last_idx;
  fppa_pkg::size_t   cur_amt;
  fppa_pkg::size_t   cur_cap;
  fppa_pkg::size_t   cur_free;
  logic              cur_take;
  logic              slot_free;

  // Active partitions: the count saturates at the memory depth.
  always_comb begin
    if (partition_count > fppa_pkg::count_t'(NUM_PARTITIONS)) begin
      count_sat = fppa_pkg::count_t'(NUM_PARTITIONS);
    end else begin
      count_sat = partition_count;
    end
    count_zero = (count_sat == '0);
    last_idx   = count_zero ? '0 : idx_t'(count_sat - 3'd1);
  end

  // The scan reads one entry ahead: the first read is issued with the request
  // transfer, and each scan cycle issues the read for the next partition.
  always_comb begin
    rd_addr = '0;
    if (state == ST_SCAN && scan_idx != last_idx) begin
      rd_addr = scan_idx + idx_t'(1);
    end
  end

  assign slot_free = !res_valid || res.ready;
  assign wr_en     = (state == ST_FINISH) && found && slot_free;

  always_ff @(posedge clk) begin
    rd_amt   <= alloc_mem[rd_addr];
    rd_valid <= alloc_valid[rd_addr];
    if (wr_en) begin
      alloc_mem[pick_idx] <= pick_amt + req_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_valid <= '0;
    end else if (wr_en) begin
      alloc_valid[pick_idx] <= 1'b1;
    end
  end

  // Free space of the partition whose amount is on the read port this cycle.
  // A capacity rewritten below the allocated amount leaves no free space.
  always_comb begin
    cur_amt  = rd_valid ? rd_amt : '0;
    cur_cap  = part_size[fppa_pkg::PART_W'(scan_idx)];
    cur_free = (cur_cap > cur_amt) ? (cur_cap - cur_amt) : '0;
    cur_take = 1'b0;
    if (cur_free >= req_size) begin
      if (!found) begin
        cur_take = 1'b1;
      end else if (fit_policy == fppa_pkg::FIT_BEST) begin
        cur_take = (cur_free < pick_free);
      end else if (fit_policy == fppa_pkg::FIT_WORST) begin
        cur_take = (cur_free > pick_free);
      end
    end
  end

  assign req.ready            = (state == ST_IDLE);
  assign cfg.ready            = 1'b1;
  assign res.valid            = res_valid;
  assign res.granted          = res_granted;
  assign res.chosen_partition = res_partition;
  assign res.free_after       = res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      res_valid       <= 1'b0;
      found           <= 1'b0;
      fit_policy      <= fppa_pkg::FIT_POLICY_RESET;
      partition_count <= fppa_pkg::PARTITION_COUNT_RESET;
      part_size       <= fppa_pkg::SIZE_RESET;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          fppa_pkg::CFG_FIT_POLICY: begin
            fit_policy <= cfg.data[fppa_pkg::POLICY_W-1:0];
          end
          fppa_pkg::CFG_PARTITION_COUNT: begin
            partition_count <= cfg.data[fppa_pkg::COUNT_W-1:0];
          end
          default: begin
            part_size[cfg.index - fppa_pkg::CFG_PARTITION0_SIZE] <= cfg.data;
          end
        endcase
      end

      // In the finish state a free slot is reloaded below instead.
      if (res_valid && res.ready && state != ST_FINISH) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            req_size  <= req.request_size;
            scan_idx  <= '0;
            found     <= 1'b0;
            pick_idx  <= '0;
            pick_free <= '0;
            pick_amt  <= '0;
            // A zero request or no active partition is refused without a scan.
            if (req.request_size == '0 || count_zero) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (cur_take) begin
            found     <= 1'b1;
            pick_idx  <= scan_idx;
            pick_free <= cur_free;
            pick_amt  <= cur_amt;
          end
          if (scan_idx == last_idx) begin
            state <= ST_FINISH;
          end else begin
            scan_idx <= scan_idx + idx_t'(1);
          end
        end
        ST_FINISH: begin
          // The write-back and the result load happen in the same cycle, once
          // the result register is free.
          if (slot_free) begin
            res_valid <= 1'b1;
            if (found) begin
              res_granted   <= 1'b1;
              res_partition <= fppa_pkg::PART_W'(pick_idx);
              res_free      <= pick_free - req_size;
            end else begin
              res_granted   <= 1'b0;
              res_partition <= '0;
              res_free      <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== verif/tb_fit_policy_partition_allocator_unit.sv =====
`timescale 1ns / 1ps

module tb_fit_policy_partition_allocator_unit;
  import fppa_pkg::*;

  localparam int NUM_PART      = 6;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ROUNDS = 12;
  localparam int ROUND_ITEMS   = 160;
  localparam int REPORT_LIMIT  = 10;

  // The package names three policy codes; the fourth one must act as first fit.
  localparam policy_t FIT_UNUSED = 2'd3;

  // One placement decision as the result channel reports it.
  typedef struct packed {
    logic  granted;
    part_t part;
    size_t room_left;
  } placement_t;

  // Tracks the register file and the allocated amount of every partition, and
  // keeps the placements that accepted requests must produce, oldest first.
  class partition_ledger;
    policy_t     policy;
    count_t      count;
    int unsigned cap [NUM_PART];
    int unsigned used [NUM_PART];
    placement_t  expected_grants [$];
    int unsigned mismatches;

    function new();
      policy = FIT_POLICY_RESET;
      count  = PARTITION_COUNT_RESET;
      for (int p = 0; p < NUM_PART; p++) begin
        cap[p]  = SIZE_RESET[p];
        used[p] = 0;
      end
      mismatches = 0;
    endfunction

    // A capacity rewritten below the allocated amount leaves no room at all.
    function int unsigned free_units(int p);
      return (cap[p] > used[p]) ? cap[p] - used[p] : 0;
    endfunction

    function int unsigned pending();
      return expected_grants.size();
    endfunction

    function void write_reg(cfg_idx_t idx, size_t data);
      if (idx == CFG_FIT_POLICY) begin
        policy = data[POLICY_W-1:0];
      end else if (idx == CFG_PARTITION_COUNT) begin
        count = data[COUNT_W-1:0];
      end else begin
        cap[idx - CFG_PARTITION0_SIZE] = data;
      end
    endfunction

    // Scans the active partitions the way the policy asks and books the winner.
    function void log_request(size_t req);
      placement_t  want;
      int unsigned active;
      int unsigned best_room;
      int unsigned room;
      int          pick;
      bit          found;
      active    = (count > NUM_PART) ? NUM_PART : count;
      found     = 1'b0;
      pick      = 0;
      best_room = 0;
      want      = '0;
      if (req != 0) begin
        for (int p = 0; p < active; p++) begin
          room = free_units(p);
          // Strict compares keep ties on the lowest index.
          if (room >= req && (!found || (policy == FIT_BEST && room < best_room) ||
                              (policy == FIT_WORST && room > best_room))) begin
            found     = 1'b1;
            pick      = p;
            best_room = room;
          end
        end
      end
      if (found) begin
        used[pick]     += req;
        want.granted   = 1'b1;
        want.part      = part_t'(pick);
        want.room_left = size_t'(best_room - req);
      end
      expected_grants.push_back(want);
    endfunction

    function void report(string what, placement_t want, placement_t seen);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%s: expected granted=%0d partition=%0d free=%0d, got granted=%0d %s%0d %s%0d",
                 what, want.granted, want.part, want.room_left, seen.granted,
                 "partition=", seen.part, "free=", seen.room_left);
      end
    endfunction

    function void match_grant(logic granted, part_t part, size_t room_left);
      placement_t seen;
      placement_t want;
      seen.granted   = granted;
      seen.part      = part;
      seen.room_left = room_left;
      if (expected_grants.size() == 0) begin
        report("result with no request outstanding", '0, seen);
      end else begin
        want = expected_grants.pop_front();
        if (seen.granted !== want.granted || seen.part !== want.part ||
            seen.room_left !== want.room_left) begin
          report("placement mismatch", want, seen);
        end
      end
    endfunction

    function void close_out();
      if (expected_grants.size() != 0) begin
        mismatches++;
        $display("%0d placements never arrived", expected_grants.size());
      end
    endfunction
  endclass

  logic            clk;
  logic            rst;
  fppa_req_if      req_ch ();
  fppa_res_if      res_ch ();
  fppa_cfg_if      cfg_ch ();
  partition_ledger ledger;
  size_t           caps [NUM_PART];
  bit              sender_idles   = 1'b0;
  bit              receiver_idles = 1'b0;
  bit              hold_results   = 1'b0;
  int unsigned     cycles         = 0;

  fit_policy_partition_allocator_unit #(
    .NUM_PARTITIONS(NUM_PART)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A hung handshake or a lost result must not let the run go on forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_fit_policy_partition_allocator_unit: done, errors");
      $finish;
    end
  end

  // Every result transfer is checked against the oldest outstanding placement.
  // Sampling at the edge sees the values from before the edge, so the check
  // does not depend on the order of processes within the time step.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      ledger.match_grant(res_ch.granted, res_ch.chosen_partition, res_ch.free_after);
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Result side. Besides the random stalls there is one long hold-off, counted
  // here, during which the sender keeps offering requests until the block
  // fills up and drops its request ready.
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap_length()) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one request and returns at the edge of its transfer. Valid is left
  // high between back-to-back requests; a gap lowers it first.
  task automatic send_request(input size_t size);
    if (sender_idles && $urandom_range(0, 2) == 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap_length()) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.request_size <= size;
    do @(posedge clk); while (!req_ch.ready);
    ledger.log_request(size);
  endtask

  // Stops offering requests and waits for every placement to come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input size_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    ledger.write_reg(idx, data);
  endtask

  // Rewrites the whole register file with the block idle. The write-back of the
  // allocated amount happens with the load of its result, so none is still
  // pending once every placement has come back.
  task automatic apply_setting(input size_t policy_word, input size_t count_word);
    drain_results();
    repeat (NUM_PART + 2) @(posedge clk);
    write_reg(CFG_FIT_POLICY, policy_word);
    write_reg(CFG_PARTITION_COUNT, count_word);
    for (int p = 0; p < NUM_PART; p++) begin
      write_reg(cfg_idx_t'(CFG_PARTITION0_SIZE + p), caps[p]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Allocated amounts only ever grow, so most capacities are set a little
  // above what is already in use to keep grants coming. The rest are full,
  // below the allocation, at the top of the range or anywhere at all.
  task automatic draw_caps();
    int unsigned mode;
    int unsigned target;
    for (int p = 0; p < NUM_PART; p++) begin
      mode = $urandom_range(0, 99);
      if (mode < 66) begin
        target = ledger.used[p] + $urandom_range(100, 4000);
      end else if (mode < 78) begin
        target = ledger.used[p];
      end else if (mode < 90) begin
        target = ledger.used[p] / 2;
      end else if (mode < 95) begin
        target = 65535;
      end else begin
        target = $urandom_range(0, 65535);
      end
      caps[p] = size_t'((target > 65535) ? 65535 : target);
    end
  endtask

  function automatic size_t random_policy_word();
    policy_t code;
    case ($urandom_range(0, 7))
      0:       code = FIT_UNUSED;
      1, 2:    code = FIT_FIRST;
      3, 4:    code = FIT_BEST;
      default: code = FIT_WORST;
    endcase
    // Bits above the policy field are junk that the block must drop.
    if ($urandom_range(0, 3) == 0) begin
      return size_t'($urandom() & 32'hFFFC) | size_t'(code);
    end
    return size_t'(code);
  endfunction

  function automatic size_t random_count_word();
    count_t count;
    case ($urandom_range(0, 9))
      0:          count = '0;
      1:          count = '1;
      2, 3, 4, 5: count = count_t'($urandom_range(1, NUM_PART));
      default:    count = count_t'(NUM_PART);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      return size_t'($urandom() & 32'hFFF8) | size_t'(count);
    end
    return size_t'(count);
  endfunction

  // Most requests are small so that several land in each partition. Some hit
  // the free space of one partition exactly or miss it by one, and a few span
  // the whole field, zero included.
  function automatic size_t pick_request();
    int unsigned mode;
    int unsigned room;
    mode = $urandom_range(0, 99);
    room = ledger.free_units($urandom_range(0, NUM_PART - 1));
    if (mode < 66) return size_t'($urandom_range(1, 127));
    if (mode < 78) return (room != 0) ? size_t'(room) : size_t'($urandom_range(1, 16));
    if (mode < 84) return (room < 65535) ? size_t'(room + 1) : size_t'(room);
    if (mode < 93) return size_t'($urandom_range(128, 2000));
    if (mode < 98) return size_t'($urandom());
    return '0;
  endfunction

  initial begin
    int unsigned lightest;

    ledger = new();
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.request_size <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_FIT_POLICY;
    cfg_ch.data         <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, first fit: a zero request, an exact fill, the largest
    // request with no room anywhere, one unit over the biggest free space.
    send_request(16'd0);
    send_request(16'd50);
    send_request(16'd1);
    send_request(16'hFFFF);
    send_request(16'd201);
    send_request(16'd200);
    send_request(16'd60);
    send_request(16'd7);

    // Best fit with the same free space everywhere, so ties must go to the
    // lowest index, then the tightest partition wins.
    for (int p = 0; p < NUM_PART; p++) caps[p] = size_t'(ledger.used[p] + 40);
    apply_setting(size_t'(FIT_BEST), size_t'(NUM_PART));
    send_request(16'd10);
    send_request(16'd30);
    send_request(16'd35);
    send_request(16'd1);

    // Worst fit with a tie on the largest free space and an empty partition.
    caps[0] = size_t'(ledger.used[0] + 10);
    caps[1] = size_t'(ledger.used[1] + 70);
    caps[2] = size_t'(ledger.used[2] + 70);
    caps[3] = size_t'(ledger.used[3] + 20);
    caps[4] = size_t'(ledger.used[4] + 5);
    caps[5] = size_t'(ledger.used[5]);
    apply_setting(size_t'(FIT_WORST), size_t'(NUM_PART));
    send_request(16'd50);
    send_request(16'd60);
    send_request(16'd11);

    // The unused policy code, a count above the partition total with junk
    // above it, and partition zero shrunk below what it already holds.
    caps[0] = '0;
    for (int p = 1; p < NUM_PART; p++) caps[p] = size_t'(ledger.used[p] + 3);
    apply_setting(16'hFFFC | size_t'(FIT_UNUSED), 16'hFFF8 | size_t'(3'd7));
    send_request(16'd5);
    send_request(16'd2);

    // No partition in use: everything is refused.
    apply_setting(size_t'(FIT_BEST), '0);
    send_request(16'd1);
    send_request(16'hFFFF);

    // Random rounds, each under a fresh register setting. Some rounds have no
    // gaps on one side or the other so the block also runs at full rate.
    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      draw_caps();
      apply_setting(random_policy_word(), random_count_word());
      sender_idles   = (r % 3) != 0;
      receiver_idles = (r % 4) != 1;
      if (r == 2) hold_results = 1'b1;
      for (int i = 0; i < ROUND_ITEMS; i++) begin
        send_request(pick_request());
        // Once, the sender stops halfway and lets the pipeline run dry.
        if (r == 5 && i == ROUND_ITEMS / 2) drain_results();
      end
    end

    // Worst fit with every partition full except the emptiest, which is
    // opened to the top of the range and then filled by one large request.
    lightest = 0;
    for (int p = 1; p < NUM_PART; p++) begin
      if (ledger.used[p] < ledger.used[lightest]) lightest = p;
    end
    for (int p = 0; p < NUM_PART; p++) caps[p] = size_t'(ledger.used[p]);
    caps[lightest] = 16'hFFFF;
    sender_idles   = 1'b0;
    apply_setting(size_t'(FIT_WORST), size_t'(NUM_PART));
    send_request(size_t'(65535 - ledger.used[lightest]));
    send_request(16'd1);

    drain_results();
    repeat (4 * (NUM_PART + 2)) @(posedge clk);
    ledger.close_out();
    if (ledger.mismatches == 0) begin
      $display("tb_fit_policy_partition_allocator_unit: done, clean");
    end else begin
      $display("tb_fit_policy_partition_allocator_unit: done, errors");
    end
    $finish;
  end

endmodule
